[rtl/bissc_frame_receiver_defines.svh]
// ----------------------------------------------------------------------------
// BiSS-C frame receiver assertion macros
// Concurrent checks on the receiver's clock, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef BISSC_FRAME_RECEIVER_DEFINES_SVH
`define BISSC_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define BISSC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BISSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define BISSC_ASSERT_SAME(lbl, ante, cons, msg)
`define BISSC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/bissc_pkg.sv]
// ----------------------------------------------------------------------------
// BiSS-C frame receiver package
// Shared types, constants and a CRC6 step helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bissc_pkg;

	localparam int MAX_POSITION_BITS = 31;
	localparam int MAX_TURN_BITS     = 24;
	localparam int MIN_POSITION_BITS = 8;
	localparam int CRC_BITS          = 6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// reset values of the configuration registers
	localparam logic [4:0]  RST_POS_BITS  = 5'd24;
	localparam logic [4:0]  RST_TURN_BITS = 5'd0;
	localparam logic [30:0] RST_ORIGIN    = 31'd0;
	localparam logic [7:0]  RST_LIMIT     = 8'd16;
	localparam logic [31:0] RST_OFFSET    =
		{RST_ORIGIN[30], RST_ORIGIN} - (32'd1 << (RST_POS_BITS - 5'd1));

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_ACK   = 3'd1;
	localparam logic [2:0] ST_NO_START = 3'd2;
	localparam logic [2:0] ST_NO_CDS   = 3'd3;
	localparam logic [2:0] ST_CRC_ERR  = 3'd4;
	localparam logic [2:0] ST_ERR_BIT  = 3'd5;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_SYNC = 4'd1,
		PH_ACK  = 4'd2,
		PH_CDS  = 4'd3,
		PH_TURN = 4'd4,
		PH_POS  = 4'd5,
		PH_ERR  = 4'd6,
		PH_WRN  = 4'd7,
		PH_CRC  = 4'd8
	} phase_t;

	// effective configuration as seen by the frame core
	typedef struct packed {
		logic [4:0]  pos_bits;     // saturated to 8..31
		logic [4:0]  turn_bits;    // saturated to 0..24
		logic        err_invert;
		logic        wrn_invert;
		logic [7:0]  sync_limit;
		logic [7:0]  ack_limit;
		logic        combine_turns;
		logic [31:0] offset;       // origin minus half counts
	} cfg_t;

	typedef struct packed {
		logic        keep_clocking;
		logic        frame_done;
		logic [2:0]  status;
		logic        warn_flag;
		logic [31:0] position;
	} result_t;

	typedef struct packed {
		logic frame_open;
	} core_stat_t;

	// one MSB-first step of x^6+x+1
	function automatic logic [CRC_BITS-1:0] crc6_step(input logic [CRC_BITS-1:0] crc,
		input logic b);
		logic fb;
		fb = crc[CRC_BITS-1] ^ b;
		return {crc[CRC_BITS-2:0], 1'b0} ^ {4'b0, fb, fb};
	endfunction

endpackage

`default_nettype wire

[rtl/bissc_if.sv]
// ----------------------------------------------------------------------------
// BiSS-C frame receiver channels
// Valid/ready channels for period items in and frame results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bissc_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic slo_level;

	modport source (output valid, output req_type, output slo_level, input ready);
	modport sink   (input valid, input req_type, input slo_level, output ready);
endinterface

interface bissc_out_if;
	logic        valid;
	logic        ready;
	logic        keep_clocking;
	logic        frame_done;
	logic [2:0]  status;
	logic        warn_flag;
	logic [31:0] position;

	modport source (output valid, output keep_clocking, output frame_done, output status,
		output warn_flag, output position, input ready);
	modport sink   (input valid, input keep_clocking, input frame_done, input status,
		input warn_flag, input position, output ready);
endinterface

`default_nettype wire

[rtl/bissc_frame_receiver.sv]
// ----------------------------------------------------------------------------
// BiSS-C frame receiver
// Master-side receive path: frame sequencing, CRC6 check, position build.
// ----------------------------------------------------------------------------
// Usage:
//  item_in carries one request per item: req_type 0 opens a frame, req_type 1
//  is one MA clock period with the sampled SLO level. item_out returns exactly
//  one result per input item: keep_clocking, frame_done, status, warn_flag and
//  the centered position (valid only on a good final result).
//  Configuration must be written through cfg_we/cfg_index/cfg_wdata only
//  while idle; the block does not enforce this. An item enters the input
//  register when accepted; its result enters the result register (driving
//  item_out.valid) once free. Throughput: one item per cycle while item_out
//  does not stall, set by the frame core's single-pass update in between.
//  Reset: valid flags clear, configuration takes its defaults, core is idle.
//  When item_out stalls, the result register holds and one more item can be
//  parked in the input register; item_in.ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bissc_frame_receiver_defines.svh"

module bissc_frame_receiver
	import bissc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	bissc_in_if.sink                   item_in,
	bissc_out_if.source                item_out,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t       cfg;
	result_t    core_res;
	result_t    res_q;
	core_stat_t core_stat;
	logic       valid_s1;
	logic       req_s1;
	logic       slo_s1;
	logic       out_valid_q;
	logic       s2_free;
	logic       move_s1;
	logic       accept_in;

	assign s2_free       = !out_valid_q || item_out.ready;
	assign move_s1       = valid_s1 && s2_free;
	assign item_in.ready = !valid_s1 || s2_free;
	assign accept_in     = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			req_s1 <= item_in.req_type;
			slo_s1 <= item_in.slo_level;
		end
	end

	bissc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bissc_frame_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (move_s1),
		.req_type  (req_s1),
		.slo_level (slo_s1),
		.cfg       (cfg),
		.res       (core_res),
		.stat      (core_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (item_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_q <= core_res;
		end
	end

	assign item_out.valid         = out_valid_q;
	assign item_out.keep_clocking = res_q.keep_clocking;
	assign item_out.frame_done    = res_q.frame_done;
	assign item_out.status        = res_q.status;
	assign item_out.warn_flag     = res_q.warn_flag;
	assign item_out.position      = res_q.position;

	`BISSC_ASSERT_NEXT(a_step_gives_result, move_s1, out_valid_q, "processed item lost")
	`BISSC_ASSERT_NEXT(a_start_opens, move_s1 && !req_s1, core_stat.frame_open, "start ignored")
	`BISSC_ASSERT_NEXT(a_done_closes, move_s1 && core_res.frame_done, !core_stat.frame_open, "frame not closed")
	`BISSC_ASSERT_SAME(a_done_stops_clock, move_s1 && core_res.frame_done, !core_res.keep_clocking, "clocking after done")

endmodule

`default_nettype wire

[rtl/bissc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// BiSS-C configuration registers
// Write-only register bank; derives saturated bit counts and position offset.
// ----------------------------------------------------------------------------
`default_nettype none

module bissc_cfg_regs
	import bissc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	localparam logic [CFG_IDX_W-1:0] REG_POS_BITS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_BITS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_INV   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRN_INV   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_LIM  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_LIM   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COMBINE   = 3'd7;

	logic [4:0]  pos_bits_q;
	logic [4:0]  turn_bits_q;
	logic [30:0] origin_q;
	logic        err_inv_q;
	logic        wrn_inv_q;
	logic [7:0]  sync_lim_q;
	logic [7:0]  ack_lim_q;
	logic        combine_q;
	logic [31:0] offset_q;
	logic [4:0]  pb_eff;
	logic [4:0]  tb_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_bits_q  <= RST_POS_BITS;
			turn_bits_q <= RST_TURN_BITS;
			origin_q    <= RST_ORIGIN;
			err_inv_q   <= 1'b1;
			wrn_inv_q   <= 1'b1;
			sync_lim_q  <= RST_LIMIT;
			ack_lim_q   <= RST_LIMIT;
			combine_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POS_BITS:  pos_bits_q  <= cfg_wdata[4:0];
				REG_TURN_BITS: turn_bits_q <= cfg_wdata[4:0];
				REG_ORIGIN:    origin_q    <= cfg_wdata[30:0];
				REG_ERR_INV:   err_inv_q   <= cfg_wdata[0];
				REG_WRN_INV:   wrn_inv_q   <= cfg_wdata[0];
				REG_SYNC_LIM:  sync_lim_q  <= cfg_wdata[7:0];
				REG_ACK_LIM:   ack_lim_q   <= cfg_wdata[7:0];
				REG_COMBINE:   combine_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign pb_eff = (pos_bits_q < 5'(MIN_POSITION_BITS)) ? 5'(MIN_POSITION_BITS) : pos_bits_q;
	assign tb_eff = (turn_bits_q > 5'(MAX_TURN_BITS)) ? 5'(MAX_TURN_BITS) : turn_bits_q;

	// precomputed so the final add in the core is a single 32-bit add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= RST_OFFSET;
		end else begin
			offset_q <= {origin_q[30], origin_q} - (32'd1 << (pb_eff - 5'd1));
		end
	end

	always_comb begin
		cfg.pos_bits      = pb_eff;
		cfg.turn_bits     = tb_eff;
		cfg.err_invert    = err_inv_q;
		cfg.wrn_invert    = wrn_inv_q;
		cfg.sync_limit    = sync_lim_q;
		cfg.ack_limit     = ack_lim_q;
		cfg.combine_turns = combine_q;
		cfg.offset        = offset_q;
	end

endmodule

`default_nettype wire

[rtl/bissc_frame_core.sv]
// ----------------------------------------------------------------------------
// BiSS-C frame core
// Phase sequencer, shift registers and CRC6 for one sampled SLO bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bissc_frame_core
	import bissc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic req_type,
	input  wire logic slo_level,
	input  wire cfg_t cfg,
	output result_t   res,
	output core_stat_t stat
);

	phase_t                     phase_q, phase_n;
	logic [7:0]                 period_q, period_n, period_inc;
	logic [4:0]                 bit_cnt_q, bit_cnt_n, bit_inc;
	logic [MAX_TURN_BITS-1:0]   turn_q, turn_n;
	logic [MAX_POSITION_BITS-1:0] pos_q, pos_n;
	logic                       err_q, err_n;
	logic                       wrn_q, wrn_n;
	logic [CRC_BITS-1:0]        crc_q, crc_n, crc_step;
	logic [CRC_BITS-1:0]        crc_rx_q, crc_rx_n, crc_rx_shift;
	logic [MAX_TURN_BITS-1:0]   turn_mask;
	logic [MAX_POSITION_BITS-1:0] pos_mask;
	logic [31:0]                merged;
	logic                       done;
	logic                       err_active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			period_q  <= '0;
			bit_cnt_q <= '0;
			turn_q    <= '0;
			pos_q     <= '0;
			err_q     <= 1'b1;
			wrn_q     <= 1'b1;
			crc_q     <= '0;
			crc_rx_q  <= '0;
		end else if (step) begin
			phase_q   <= phase_n;
			period_q  <= period_n;
			bit_cnt_q <= bit_cnt_n;
			turn_q    <= turn_n;
			pos_q     <= pos_n;
			err_q     <= err_n;
			wrn_q     <= wrn_n;
			crc_q     <= crc_n;
			crc_rx_q  <= crc_rx_n;
		end
	end

	assign period_inc   = (period_q == 8'hFF) ? period_q : 8'(period_q + 8'd1);
	assign bit_inc      = 5'(bit_cnt_q + 5'd1);
	assign crc_step     = crc6_step(crc_q, slo_level);
	assign crc_rx_shift = {crc_rx_q[CRC_BITS-2:0], slo_level};
	assign turn_mask    = ~({MAX_TURN_BITS{1'b1}} << cfg.turn_bits);
	assign pos_mask     = ~({MAX_POSITION_BITS{1'b1}} << cfg.pos_bits);
	// turn bits above 32 fall off the shift
	assign merged       = {1'b0, pos_q} |
		(cfg.combine_turns ? (32'(turn_q) << cfg.pos_bits) : 32'd0);
	assign err_active   = cfg.err_invert ? !err_q : err_q;

	always_comb begin
		phase_n   = phase_q;
		period_n  = period_q;
		bit_cnt_n = bit_cnt_q;
		turn_n    = turn_q;
		pos_n     = pos_q;
		err_n     = err_q;
		wrn_n     = wrn_q;
		crc_n     = crc_q;
		crc_rx_n  = crc_rx_q;
		done      = 1'b0;
		res       = '0;

		if (!req_type) begin
			phase_n   = PH_SYNC;
			period_n  = '0;
			bit_cnt_n = '0;
			turn_n    = '0;
			pos_n     = '0;
			err_n     = 1'b1;
			wrn_n     = 1'b1;
			crc_n     = '0;
			crc_rx_n  = '0;
			res.keep_clocking = 1'b1;
		end else begin
			res.keep_clocking = 1'b1;
			unique case (phase_q)
				PH_SYNC: begin
					if (!slo_level) begin
						phase_n  = PH_ACK;
						period_n = '0;
					end else begin
						period_n = period_inc;
						if (period_inc >= cfg.sync_limit) begin
							done       = 1'b1;
							res.status = ST_NO_ACK;
						end
					end
				end
				PH_ACK: begin
					if (slo_level) begin
						phase_n  = PH_CDS;
						period_n = '0;
					end else begin
						period_n = period_inc;
						if (period_inc >= cfg.ack_limit) begin
							done       = 1'b1;
							res.status = ST_NO_START;
						end
					end
				end
				PH_CDS: begin
					if (!slo_level) begin
						phase_n   = (cfg.turn_bits == 5'd0) ? PH_POS : PH_TURN;
						bit_cnt_n = '0;
					end else begin
						done       = 1'b1;
						res.status = ST_NO_CDS;
					end
				end
				PH_TURN: begin
					turn_n    = {turn_q[MAX_TURN_BITS-2:0], slo_level} & turn_mask;
					crc_n     = crc_step;
					bit_cnt_n = bit_inc;
					if (bit_inc >= cfg.turn_bits) begin
						phase_n   = PH_POS;
						bit_cnt_n = '0;
					end
				end
				PH_POS: begin
					pos_n     = {pos_q[MAX_POSITION_BITS-2:0], slo_level} & pos_mask;
					crc_n     = crc_step;
					bit_cnt_n = bit_inc;
					if (bit_inc >= cfg.pos_bits) begin
						phase_n   = PH_ERR;
						bit_cnt_n = '0;
					end
				end
				PH_ERR: begin
					err_n   = slo_level;
					crc_n   = crc_step;
					phase_n = PH_WRN;
				end
				PH_WRN: begin
					wrn_n     = slo_level;
					crc_n     = crc_step;
					phase_n   = PH_CRC;
					bit_cnt_n = '0;
				end
				PH_CRC: begin
					crc_rx_n  = crc_rx_shift;
					bit_cnt_n = bit_inc;
					if (bit_inc >= 5'(CRC_BITS)) begin
						done = 1'b1;
						// transmitted CRC is inverted
						if (~crc_q != crc_rx_shift) begin
							res.status = ST_CRC_ERR;
						end else begin
							res.warn_flag = cfg.wrn_invert ? !wrn_q : wrn_q;
							if (err_active) begin
								res.status = ST_ERR_BIT;
							end else begin
								res.position = merged + cfg.offset;
							end
						end
					end
				end
				default: begin
					// idle: period ignored, all-zero result
					res.keep_clocking = 1'b0;
				end
			endcase
			if (done) begin
				res.keep_clocking = 1'b0;
				res.frame_done    = 1'b1;
				phase_n           = PH_IDLE;
			end
		end
	end

	assign stat.frame_open = (phase_q != PH_IDLE);

endmodule

`default_nettype wire
